### rtl/core/sld_pkg.sv
// shared types and constants for the sync/length/xor deframer
// no dependencies; used by sld_step and sync_length_xor_deframer
`timescale 1ns / 1ps

package sld_pkg;

   // reset values of the two configuration registers
   localparam logic [31:0] SYNC_WORD_RESET = 32'h554E_4552;
   localparam logic [7:0]  SEPARATOR_RESET = 8'h3A;

   // smallest legal length byte (command plus checksum)
   localparam logic [7:0] MIN_LENGTH = 8'd2;

   // configuration register indexes
   localparam logic CSR_SYNC_WORD = 1'b0;
   localparam logic CSR_SEPARATOR = 1'b1;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   typedef enum logic [2:0] {
      PH_SYNC,
      PH_LEN,
      PH_SEP,
      PH_CMD,
      PH_PAY,
      PH_CSUM,
      PH_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SYNC,
      ST_LEN,
      ST_TRUNC,
      ST_CSUM
   } status_type;

   // parse state carried from one byte to the next
   typedef struct packed {
      phase_type  phase;
      logic [7:0] byte_position;
      logic [7:0] frame_length;
      logic [7:0] running_xor;
      logic [7:0] held_command;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      phase:         PH_SYNC,
      byte_position: 8'd0,
      frame_length:  8'd0,
      running_xor:   8'd0,
      held_command:  8'd0
   };

   // result produced by one byte
   typedef struct packed {
      logic       valid;
      logic       out_kind;
      logic [7:0] out_byte;
      logic [7:0] command_code;
      logic [7:0] payload_index;
      status_type frame_status;
   } step_result_type;

endpackage

### rtl/core/sld_step.sv
// one parse step: next state and optional result for one datagram byte
// depends on sld_pkg
`timescale 1ns / 1ps

module sld_step (
   input  sld_pkg::parse_state_type state,
   input  logic [7:0]               rx_byte,
   input  logic                     datagram_last,
   input  logic [31:0]              sync_word,
   input  logic [7:0]               separator_byte,
   output sld_pkg::parse_state_type state_next,
   output sld_pkg::step_result_type result
);

   logic [7:0] expected_sync;
   logic [7:0] pos_plus_one;
   logic [8:0] pay_reach;
   logic [7:0] xor_next;

   // expected header byte, first byte in the top bits
   always_comb begin
      case (state.byte_position[1:0])
         2'd0:    expected_sync = sync_word[31:24];
         2'd1:    expected_sync = sync_word[23:16];
         2'd2:    expected_sync = sync_word[15:8];
         default: expected_sync = sync_word[7:0];
      endcase
   end

   assign pos_plus_one = state.byte_position + 8'd1;
   assign pay_reach    = {1'b0, pos_plus_one} + {1'b0, sld_pkg::MIN_LENGTH};
   assign xor_next     = state.running_xor ^ rx_byte;

   // phase decode
   always_comb begin
      sld_pkg::status_type end_status;
      logic [7:0]          end_index;
      logic                end_now;

      state_next = state;
      end_status = sld_pkg::ST_OK;
      end_index  = 8'd0;
      end_now    = 1'b0;
      result     = '{
         valid:         1'b0,
         out_kind:      sld_pkg::KIND_PAYLOAD,
         out_byte:      8'd0,
         command_code:  state.held_command,
         payload_index: 8'd0,
         frame_status:  sld_pkg::ST_OK
      };

      case (state.phase)
         sld_pkg::PH_SYNC: begin
            if (rx_byte != expected_sync) begin
               end_now    = 1'b1;
               end_status = sld_pkg::ST_SYNC;
            end else begin
               state_next.running_xor = xor_next;
               if (state.byte_position[1:0] == 2'd3) begin
                  state_next.byte_position = 8'd0;
                  state_next.phase         = sld_pkg::PH_LEN;
               end else begin
                  state_next.byte_position = {6'd0, state.byte_position[1:0]} + 8'd1;
               end
               end_now    = datagram_last;
               end_status = sld_pkg::ST_TRUNC;
            end
         end
         sld_pkg::PH_LEN: begin
            if (rx_byte < sld_pkg::MIN_LENGTH) begin
               end_now    = 1'b1;
               end_status = sld_pkg::ST_LEN;
            end else begin
               state_next.frame_length = rx_byte;
               state_next.running_xor  = xor_next;
               state_next.phase        = sld_pkg::PH_SEP;
               end_now                 = datagram_last;
               end_status              = sld_pkg::ST_TRUNC;
            end
         end
         sld_pkg::PH_SEP: begin
            if (rx_byte != separator_byte) begin
               end_now    = 1'b1;
               end_status = sld_pkg::ST_LEN;
            end else begin
               state_next.running_xor = xor_next;
               state_next.phase       = sld_pkg::PH_CMD;
               end_now                = datagram_last;
               end_status             = sld_pkg::ST_TRUNC;
            end
         end
         sld_pkg::PH_CMD: begin
            state_next.held_command  = rx_byte;
            state_next.running_xor   = xor_next;
            state_next.byte_position = 8'd0;
            state_next.phase         = (state.frame_length <= sld_pkg::MIN_LENGTH) ?
                                       sld_pkg::PH_CSUM : sld_pkg::PH_PAY;
            end_now                  = datagram_last;
            end_status               = sld_pkg::ST_TRUNC;
         end
         sld_pkg::PH_PAY: begin
            state_next.running_xor = xor_next;
            if (datagram_last) begin
               end_now    = 1'b1;
               end_status = sld_pkg::ST_TRUNC;
               end_index  = state.byte_position;
            end else begin
               result.valid             = 1'b1;
               result.out_byte          = rx_byte;
               result.payload_index     = state.byte_position;
               state_next.byte_position = pos_plus_one;
               if (pay_reach >= {1'b0, state.frame_length}) begin
                  state_next.phase = sld_pkg::PH_CSUM;
               end
            end
         end
         sld_pkg::PH_CSUM: begin
            end_now    = 1'b1;
            end_status = (rx_byte == state.running_xor) ? sld_pkg::ST_OK : sld_pkg::ST_CSUM;
            end_index  = state.frame_length - sld_pkg::MIN_LENGTH;
         end
         default: begin
            // skip rest of datagram up to the last mark
            if (datagram_last) begin
               state_next = sld_pkg::PARSE_STATE_RESET;
            end
         end
      endcase

      // end result; command taken after this byte's update
      if (end_now) begin
         result.valid         = 1'b1;
         result.out_kind      = sld_pkg::KIND_END;
         result.out_byte      = 8'd0;
         result.command_code  = state_next.held_command;
         result.payload_index = end_index;
         result.frame_status  = end_status;
         if (datagram_last) begin
            state_next = sld_pkg::PARSE_STATE_RESET;
         end else begin
            state_next.phase = sld_pkg::PH_SKIP;
         end
      end
   end

endmodule

### rtl/core/sync_length_xor_deframer.sv
// top level of the sync/length/xor deframer: beat registers, config, parse state
// depends on sld_pkg and sld_step
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  req     | in        | req_valid/stall    | rx_byte, datagram_last
//  rsp     | out       | rsp_valid/stall    | out_kind, out_byte, command_code,
//          |           |                    | payload_index, frame_status
//  csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
//  One byte per cycle sustained while rsp is not stalled. A byte lands in the input
//  register, the parse step decodes it combinationally against the held state, and
//  its result (if any) is registered in the result register that drives rsp_valid.
//  Synchronous reset clears the parse state and both valid flags and reloads the config.
//  A stall on rsp holds the input register full, and req_stall rises only then.

module sync_length_xor_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_datagram_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [7:0]  rsp_command_code,
   output logic [7:0]  rsp_payload_index,
   output logic [2:0]  rsp_frame_status,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);

   logic                     in_valid_ff;
   logic [7:0]               in_byte_ff;
   logic                     in_last_ff;
   logic [31:0]              sync_word_ff;
   logic [7:0]               separator_ff;
   sld_pkg::parse_state_type state_ff;
   sld_pkg::parse_state_type state_in;
   sld_pkg::step_result_type step_result;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_kind_ff;
   logic [7:0]               rsp_byte_ff;
   logic [7:0]               rsp_command_ff;
   logic [7:0]               rsp_index_ff;
   logic [2:0]               rsp_status_ff;
   logic                     out_free;
   logic                     advance;
   logic                     req_take;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // parse step
   sld_step u_step (
      .state          (state_ff),
      .rx_byte        (in_byte_ff),
      .datagram_last  (in_last_ff),
      .sync_word      (sync_word_ff),
      .separator_byte (separator_ff),
      .state_next     (state_in),
      .result         (step_result)
   );

   // result valid next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = advance && step_result.valid;
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= sld_pkg::SYNC_WORD_RESET;
         separator_ff <= sld_pkg::SEPARATOR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sld_pkg::CSR_SYNC_WORD: sync_word_ff <= csr_write_data;
            sld_pkg::CSR_SEPARATOR: separator_ff <= csr_write_data[7:0];
            default:                sync_word_ff <= sync_word_ff;
         endcase
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
         in_last_ff <= req_datagram_last;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sld_pkg::PARSE_STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_result.valid) begin
         rsp_kind_ff    <= step_result.out_kind;
         rsp_byte_ff    <= step_result.out_byte;
         rsp_command_ff <= step_result.command_code;
         rsp_index_ff   <= step_result.payload_index;
         rsp_status_ff  <= step_result.frame_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_kind      = rsp_kind_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_command_code  = rsp_command_ff;
   assign rsp_payload_index = rsp_index_ff;
   assign rsp_frame_status  = rsp_status_ff;

endmodule
